@@ rtl/rsi_pkg.sv @@
package rsi_pkg;

	// Register map of the configuration port.
	typedef enum logic [1:0] {
		CFG_CENTER_X = 2'd0,
		CFG_CENTER_Y = 2'd1,
		CFG_CENTER_Z = 2'd2,
		CFG_RADIUS   = 2'd3
	} cfg_idx_t;

	localparam int SQ_STEPS = 64;
	localparam int DV_STEPS = 32;

	localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [2:0][31:0] o;
		logic [2:0][31:0] d;
		logic [31:0]      tmin;
		logic [31:0]      tmax;
	} ray_t;

	// Everything the middle of the pipeline needs about one ray.
	typedef struct packed {
		ray_t        ray;
		logic        inner;
		logic        miss;
		logic [63:0] hm;
		logic        hneg;
		logic [63:0] a;
	} ctx_t;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		logic [31:0] r;
		r = v[31] ? 32'(-v) : 32'(v);
		return r;
	endfunction

	function automatic logic [31:0] sat_s66(input logic signed [65:0] v);
		logic [31:0] r;
		if (v > 66'sd2147483647) begin
			r = Q_MAX;
		end else if (v < -66'sd2147483648) begin
			r = Q_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/ray_sphere_intersect_unit.sv @@
// Ray against sphere intersection pipeline, signed fixed point with FRAC_BITS
// fraction bits in 32-bit words.
// The sphere (center and radius) is set through the configuration port: a write
// lands when cfg_valid is high; cfg_ready is always high. Write it only while
// no ray is in flight.
// Rays enter on the request channel (in_valid / in_stall) with origin,
// direction and the accepted t window. Each ray gives exactly one result on
// the output channel (out_valid / out_stall): is_hit, t, the hit point and the
// surface normal, all zero on a miss.
// A new ray can be taken in every cycle in which in_stall is low. The pipeline
// holds the 64-step square root, the 32-step quotient for t and the
// (33 + FRAC_BITS)-step divider for the normal, one step per stage; with the
// default FRAC_BITS of 16 the words are Q16.16.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall is raised in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and sets the sphere to center 0, radius 1.0.
module ray_sphere_intersect_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [31:0]   origin_x,
	input  logic signed [31:0]   origin_y,
	input  logic signed [31:0]   origin_z,
	input  logic signed [31:0]   dir_x,
	input  logic signed [31:0]   dir_y,
	input  logic signed [31:0]   dir_z,
	input  logic signed [31:0]   t_min,
	input  logic signed [31:0]   t_max,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 is_hit,
	output logic signed [31:0]   hit_t,
	output logic signed [31:0]   point_x,
	output logic signed [31:0]   point_y,
	output logic signed [31:0]   point_z,
	output logic signed [31:0]   normal_x,
	output logic signed [31:0]   normal_y,
	output logic signed [31:0]   normal_z,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  rsi_pkg::cfg_idx_t    cfg_index,
	input  logic [31:0]          cfg_data
);
	import rsi_pkg::*;

	localparam int NUMW = 65 + FRAC_BITS;
	localparam int CMPW = (NUMW > 96) ? NUMW : 96;
	localparam int NDW  = 33 + FRAC_BITS;

	logic adv;
	logic signed [31:0] cen_q [3];
	logic [30:0]        rad_q;
	logic [61:0]        rsq_q;
	logic               rzero;

	assign adv       = !(out_valid && out_stall);
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;
	assign rzero     = (rad_q == 31'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cen_q[0] <= '0;
			cen_q[1] <= '0;
			cen_q[2] <= '0;
			rad_q    <= 31'(64'd1 << FRAC_BITS);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CENTER_X: cen_q[0] <= cfg_data;
				CFG_CENTER_Y: cen_q[1] <= cfg_data;
				CFG_CENTER_Z: cen_q[2] <= cfg_data;
				CFG_RADIUS:   rad_q    <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rsq_q <= 62'(rad_q) * 62'(rad_q);
	end

	// Stage 1: capture, origin minus center.
	logic               v_s1;
	ray_t               ray_s1;
	logic signed [31:0] oc_s1 [3];
	logic signed [31:0] o_in [3];

	assign o_in[0] = origin_x;
	assign o_in[1] = origin_y;
	assign o_in[2] = origin_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ray_s1.o    <= {origin_z, origin_y, origin_x};
			ray_s1.d    <= {dir_z, dir_y, dir_x};
			ray_s1.tmin <= t_min;
			ray_s1.tmax <= t_max;
			for (int i = 0; i < 3; i++) begin
				oc_s1[i] <= sat_s66(66'(o_in[i]) - 66'(cen_q[i]));
			end
		end
	end

	// Stage 2: per-axis products.
	logic        v_s2;
	ray_t        ray_s2;
	logic [63:0] ocsq_s2 [3];
	logic [63:0] dsq_s2 [3];
	logic [63:0] pr_s2 [3];
	logic        prneg_s2 [3];
	logic [31:0] oc_mag [3];
	logic [31:0] d_mag [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			oc_mag[i] = mag32(oc_s1[i]);
			d_mag[i]  = mag32(ray_s1.d[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ray_s2 <= ray_s1;
			for (int i = 0; i < 3; i++) begin
				ocsq_s2[i]  <= 64'(oc_mag[i]) * 64'(oc_mag[i]);
				dsq_s2[i]   <= 64'(d_mag[i]) * 64'(d_mag[i]);
				pr_s2[i]    <= 64'(oc_mag[i]) * 64'(d_mag[i]);
				prneg_s2[i] <= oc_s1[i][31] != ray_s1.d[i][31];
			end
		end
	end

	// Stage 3: sums of squares and of the signed dot product halves.
	logic        v_s3;
	ray_t        ray_s3;
	logic [63:0] ocsq_s3, a_s3, pos_s3, neg_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ray_s3  <= ray_s2;
			ocsq_s3 <= ocsq_s2[0] + ocsq_s2[1] + ocsq_s2[2];
			a_s3    <= dsq_s2[0] + dsq_s2[1] + dsq_s2[2];
			pos_s3  <= (prneg_s2[0] ? 64'd0 : pr_s2[0]) + (prneg_s2[1] ? 64'd0 : pr_s2[1])
				+ (prneg_s2[2] ? 64'd0 : pr_s2[2]);
			neg_s3  <= (prneg_s2[0] ? pr_s2[0] : 64'd0) + (prneg_s2[1] ? pr_s2[1] : 64'd0)
				+ (prneg_s2[2] ? pr_s2[2] : 64'd0);
		end
	end

	// Stage 4: inside test, |h| and c.
	logic        v_s4;
	ctx_t        ctx_s4;
	logic [63:0] c_s4, ocsq_s4;
	logic        inside_c;

	assign inside_c = ocsq_s3 < 64'(rsq_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s4.ray   <= ray_s3;
			ctx_s4.inner <= inside_c;
			ctx_s4.miss  <= rzero || (!inside_c && a_s3 == 64'd0);
			ctx_s4.hm    <= (pos_s3 >= neg_s3) ? pos_s3 - neg_s3 : neg_s3 - pos_s3;
			ctx_s4.hneg  <= pos_s3 < neg_s3;
			ctx_s4.a     <= a_s3;
			c_s4         <= ocsq_s3 - 64'(rsq_q);
			ocsq_s4      <= ocsq_s3;
		end
	end

	// Stage 5: 32x32 partial products of h*h and a*c.
	logic        v_s5;
	ctx_t        ctx_s5;
	logic [63:0] ocsq_s5;
	logic [63:0] hh00_s5, hh01_s5, hh11_s5;
	logic [63:0] ac00_s5, ac01_s5, ac10_s5, ac11_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s5  <= ctx_s4;
			ocsq_s5 <= ocsq_s4;
			hh00_s5 <= 64'(ctx_s4.hm[31:0]) * 64'(ctx_s4.hm[31:0]);
			hh01_s5 <= 64'(ctx_s4.hm[31:0]) * 64'(ctx_s4.hm[63:32]);
			hh11_s5 <= 64'(ctx_s4.hm[63:32]) * 64'(ctx_s4.hm[63:32]);
			ac00_s5 <= 64'(ctx_s4.a[31:0]) * 64'(c_s4[31:0]);
			ac01_s5 <= 64'(ctx_s4.a[31:0]) * 64'(c_s4[63:32]);
			ac10_s5 <= 64'(ctx_s4.a[63:32]) * 64'(c_s4[31:0]);
			ac11_s5 <= 64'(ctx_s4.a[63:32]) * 64'(c_s4[63:32]);
		end
	end

	// Stage 6: assemble the 128-bit products.
	logic         v_s6;
	ctx_t         ctx_s6;
	logic [63:0]  ocsq_s6;
	logic [127:0] hsq_s6, ac_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s6  <= ctx_s5;
			ocsq_s6 <= ocsq_s5;
			hsq_s6  <= {hh11_s5, hh00_s5} + (128'(hh01_s5) << 33);
			ac_s6   <= {ac11_s5, ac00_s5} + (128'(ac01_s5) << 32) + (128'(ac10_s5) << 32);
		end
	end

	// Square root, one result bit per stage. The operand is the distance
	// squared for an origin inside the sphere, the discriminant otherwise.
	logic         sq_v_s    [SQ_STEPS+1];
	ctx_t         sq_ctx_s  [SQ_STEPS+1];
	logic [127:0] sq_rem_s  [SQ_STEPS+1];
	logic [63:0]  sq_root_s [SQ_STEPS+1];
	logic         dneg;
	ctx_t         sq_ctx_c;

	assign dneg = hsq_s6 < ac_s6;

	always_comb begin
		sq_ctx_c      = ctx_s6;
		sq_ctx_c.miss = ctx_s6.miss || (!ctx_s6.inner && dneg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_v_s[0] <= 1'b0;
		else if (adv) sq_v_s[0] <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_ctx_s[0]  <= sq_ctx_c;
			sq_rem_s[0]  <= ctx_s6.inner ? 128'(ocsq_s6) : hsq_s6 - ac_s6;
			sq_root_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		localparam int B = SQ_STEPS - 1 - k;
		logic [127:0] trial;
		logic         take;

		assign trial = (128'(sq_root_s[k]) << (B + 1)) | (128'd1 << (2 * B));
		assign take  = sq_rem_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v_s[k+1] <= 1'b0;
			else if (adv) sq_v_s[k+1] <= sq_v_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_ctx_s[k+1]  <= sq_ctx_s[k];
				sq_rem_s[k+1]  <= take ? sq_rem_s[k] - trial : sq_rem_s[k];
				sq_root_s[k+1] <= take ? (sq_root_s[k] | (64'd1 << B)) : sq_root_s[k];
			end
		end
	end

	// Stage 8: numerator of the nearer root, and t for an inside origin.
	logic            v_s8;
	ctx_t            ctx_s8;
	logic [NUMW-1:0] numsh_s8;
	logic            numneg_s8;
	logic [31:0]     tin_s8;
	logic [63:0]     sroot;
	logic [64:0]     num_c;
	logic            numneg_c;

	assign sroot = sq_root_s[SQ_STEPS];

	always_comb begin
		if (!sq_ctx_s[SQ_STEPS].hneg) begin
			num_c    = 65'(sq_ctx_s[SQ_STEPS].hm) + 65'(sroot);
			numneg_c = 1'b1;
		end else if (sq_ctx_s[SQ_STEPS].hm >= sroot) begin
			num_c    = 65'(sq_ctx_s[SQ_STEPS].hm - sroot);
			numneg_c = 1'b0;
		end else begin
			num_c    = 65'(sroot - sq_ctx_s[SQ_STEPS].hm);
			numneg_c = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (adv) v_s8 <= sq_v_s[SQ_STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s8    <= sq_ctx_s[SQ_STEPS];
			numsh_s8  <= NUMW'(num_c) << FRAC_BITS;
			numneg_s8 <= numneg_c;
			tin_s8    <= 32'(rad_q) - sroot[31:0];
		end
	end

	// Quotient for t. A numerator at or above a * 2^32 cannot give a t in
	// range, so only 32 quotient bits are formed.
	logic        dv_v_s   [DV_STEPS+1];
	ctx_t        dv_ctx_s [DV_STEPS+1];
	logic [63:0] dv_rem_s [DV_STEPS+1];
	logic [31:0] dv_lo_s  [DV_STEPS+1];
	logic [31:0] dv_q_s   [DV_STEPS+1];
	logic        dv_neg_s [DV_STEPS+1];
	logic [31:0] dv_tin_s [DV_STEPS+1];
	logic        ovf;
	ctx_t        dv_ctx_c;

	assign ovf = CMPW'(numsh_s8) >= (CMPW'(ctx_s8.a) << 32);

	always_comb begin
		dv_ctx_c      = ctx_s8;
		dv_ctx_c.miss = ctx_s8.miss || (!ctx_s8.inner && ovf);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v_s[0] <= 1'b0;
		else if (adv) dv_v_s[0] <= v_s8;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_ctx_s[0] <= dv_ctx_c;
			dv_rem_s[0] <= 64'(numsh_s8 >> 32);
			dv_lo_s[0]  <= numsh_s8[31:0];
			dv_q_s[0]   <= '0;
			dv_neg_s[0] <= numneg_s8;
			dv_tin_s[0] <= tin_s8;
		end
	end

	for (genvar j = 0; j < DV_STEPS; j++) begin : g_tdiv
		logic [64:0] rr;
		logic        ge;

		assign rr = {dv_rem_s[j], dv_lo_s[j][31]};
		assign ge = rr >= {1'b0, dv_ctx_s[j].a};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[j+1] <= 1'b0;
			else if (adv) dv_v_s[j+1] <= dv_v_s[j];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_ctx_s[j+1] <= dv_ctx_s[j];
				dv_rem_s[j+1] <= ge ? 64'(rr - {1'b0, dv_ctx_s[j].a}) : rr[63:0];
				dv_lo_s[j+1]  <= {dv_lo_s[j][30:0], 1'b0};
				dv_q_s[j+1]   <= {dv_q_s[j][30:0], ge};
				dv_neg_s[j+1] <= dv_neg_s[j];
				dv_tin_s[j+1] <= dv_tin_s[j];
			end
		end
	end

	// Stage 9: signed t and the range check of the root.
	logic        v_s9;
	ray_t        ray_s9;
	logic        inside_s9, miss_s9;
	logic [31:0] t_s9;
	logic [31:0] q_fin;
	ctx_t        ctx_fin;

	assign q_fin   = dv_q_s[DV_STEPS];
	assign ctx_fin = dv_ctx_s[DV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (adv) v_s9 <= dv_v_s[DV_STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ray_s9    <= ctx_fin.ray;
			inside_s9 <= ctx_fin.inner;
			if (ctx_fin.inner) begin
				t_s9    <= dv_tin_s[DV_STEPS];
				miss_s9 <= ctx_fin.miss;
			end else if (dv_neg_s[DV_STEPS]) begin
				t_s9    <= 32'd0 - q_fin;
				miss_s9 <= ctx_fin.miss || (q_fin > Q_MIN);
			end else begin
				t_s9    <= q_fin;
				miss_s9 <= ctx_fin.miss || q_fin[31];
			end
		end
	end

	// Stage 10: t window.
	logic        v_s10, hit_s10, inside_s10;
	ray_t        ray_s10;
	logic [31:0] t_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s10 <= 1'b0;
		else if (adv) v_s10 <= v_s9;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ray_s10    <= ray_s9;
			t_s10      <= t_s9;
			inside_s10 <= inside_s9;
			hit_s10    <= !miss_s9 && !($signed(t_s9) < $signed(ray_s9.tmin))
				&& !($signed(t_s9) > $signed(ray_s9.tmax));
		end
	end

	// Stage 11: t * d.
	logic               v_s11, hit_s11;
	ray_t               ray_s11;
	logic [31:0]        t_s11;
	logic signed [63:0] prod_s11 [3];
	logic signed [63:0] prod_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod_c[i] = $signed(t_s10) * $signed(ray_s10.d[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s11 <= 1'b0;
		else if (adv) v_s11 <= v_s10;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ray_s11 <= ray_s10;
			t_s11   <= t_s10;
			hit_s11 <= hit_s10;
			for (int i = 0; i < 3; i++) begin
				prod_s11[i] <= prod_c[i];
			end
		end
	end

	// Stage 12: hit point.
	logic        v_s12, hit_s12;
	logic [31:0] t_s12;
	logic [31:0] p_s12 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s12 <= 1'b0;
		else if (adv) v_s12 <= v_s11;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s12   <= t_s11;
			hit_s12 <= hit_s11;
			for (int i = 0; i < 3; i++) begin
				p_s12[i] <= sat_s66(66'($signed(ray_s11.o[i])) + 66'(prod_s11[i] >>> FRAC_BITS));
			end
		end
	end

	// Normal: |point - center| * 2^FRAC_BITS / radius, three lanes of a
	// restoring divider, one quotient bit per stage.
	logic           nd_v_s   [NDW+1];
	logic           nd_hit_s [NDW+1];
	logic [31:0]    nd_t_s   [NDW+1];
	logic [31:0]    nd_p_s   [NDW+1][3];
	logic           nd_neg_s [NDW+1][3];
	logic [31:0]    nd_rem_s [NDW+1][3];
	logic [NDW-1:0] nd_dd_s  [NDW+1][3];
	logic [NDW-1:0] nd_q_s   [NDW+1][3];
	logic signed [32:0] diff_c [3];
	logic [32:0]        dmag_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff_c[i] = 33'($signed(p_s12[i])) - 33'(cen_q[i]);
			dmag_c[i] = diff_c[i][32] ? 33'(-diff_c[i]) : 33'(diff_c[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) nd_v_s[0] <= 1'b0;
		else if (adv) nd_v_s[0] <= v_s12;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nd_hit_s[0] <= hit_s12;
			nd_t_s[0]   <= t_s12;
			for (int i = 0; i < 3; i++) begin
				nd_p_s[0][i]   <= p_s12[i];
				nd_neg_s[0][i] <= diff_c[i][32];
				nd_rem_s[0][i] <= '0;
				nd_dd_s[0][i]  <= NDW'(dmag_c[i]) << FRAC_BITS;
				nd_q_s[0][i]   <= '0;
			end
		end
	end

	for (genvar k = 0; k < NDW; k++) begin : g_ndiv
		logic [32:0] rr [3];
		logic        ge [3];

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				rr[i] = {nd_rem_s[k][i], nd_dd_s[k][i][NDW-1]};
				ge[i] = rr[i] >= 33'(rad_q);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) nd_v_s[k+1] <= 1'b0;
			else if (adv) nd_v_s[k+1] <= nd_v_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				nd_hit_s[k+1] <= nd_hit_s[k];
				nd_t_s[k+1]   <= nd_t_s[k];
				for (int i = 0; i < 3; i++) begin
					nd_p_s[k+1][i]   <= nd_p_s[k][i];
					nd_neg_s[k+1][i] <= nd_neg_s[k][i];
					nd_rem_s[k+1][i] <= ge[i] ? 32'(rr[i] - 33'(rad_q)) : rr[i][31:0];
					nd_dd_s[k+1][i]  <= nd_dd_s[k][i] << 1;
					nd_q_s[k+1][i]   <= {nd_q_s[k][i][NDW-2:0], ge[i]};
				end
			end
		end
	end

	// Output register: saturate the normal, zero everything on a miss.
	logic [31:0] nrm_c [3];
	logic        hit_fin;

	assign hit_fin = nd_hit_s[NDW];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (nd_neg_s[NDW][i]) begin
				nrm_c[i] = (nd_q_s[NDW][i] > NDW'(Q_MIN)) ? Q_MIN
					: 32'd0 - nd_q_s[NDW][i][31:0];
			end else begin
				nrm_c[i] = (nd_q_s[NDW][i] > NDW'(Q_MAX)) ? Q_MAX : nd_q_s[NDW][i][31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= nd_v_s[NDW];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			is_hit   <= hit_fin;
			hit_t    <= hit_fin ? nd_t_s[NDW] : 32'd0;
			point_x  <= hit_fin ? nd_p_s[NDW][0] : 32'd0;
			point_y  <= hit_fin ? nd_p_s[NDW][1] : 32'd0;
			point_z  <= hit_fin ? nd_p_s[NDW][2] : 32'd0;
			normal_x <= hit_fin ? nrm_c[0] : 32'd0;
			normal_y <= hit_fin ? nrm_c[1] : 32'd0;
			normal_z <= hit_fin ? nrm_c[2] : 32'd0;
		end
	end

`ifndef SYNTHESIS
	// A miss must leave every payload field at zero.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_hit |-> hit_t == 32'd0 && point_x == 32'd0 && point_y == 32'd0
			&& point_z == 32'd0 && normal_x == 32'd0 && normal_y == 32'd0
			&& normal_z == 32'd0)
		else $error("miss result carries nonzero fields");

	// An origin inside the sphere always yields a positive t.
	a_inside_pos: assert property (@(posedge clk) disable iff (!arst_n)
		v_s10 && hit_s10 && inside_s10 |-> $signed(t_s10) > 0)
		else $error("inside hit with non-positive t");

	// A zero direction from outside the sphere has been marked a miss.
	a_zero_dir: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v_s[SQ_STEPS] && !sq_ctx_s[SQ_STEPS].inner && sq_ctx_s[SQ_STEPS].a == 64'd0
			|-> sq_ctx_s[SQ_STEPS].miss)
		else $error("zero direction outside not marked as miss");
`endif

endmodule

@@ tb/tb_ray_sphere_intersect_unit.sv @@
`timescale 1ns / 100ps

module tb_ray_sphere_intersect_unit;
	import rsi_pkg::*;

	localparam int FRAC = 16;
	localparam longint ONE = 64'sd65536;
	localparam longint S32_MAX = 64'sh7fff_ffff;
	localparam longint S32_MIN = -64'sh8000_0000;

	typedef struct packed {
		logic             hit;
		logic [31:0]      t;
		logic [2:0][31:0] p;
		logic [2:0][31:0] n;
	} hit_rec_t;

	class rsi_scoreboard;
		longint   cx, cy, cz, rad;
		hit_rec_t hit_q[$];
		int       errors;

		function new();
			cx = 0;
			cy = 0;
			cz = 0;
			rad = ONE;
			errors = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [31:0] v);
			case (idx)
				CFG_CENTER_X: cx = longint'($signed(v));
				CFG_CENTER_Y: cy = longint'($signed(v));
				CFG_CENTER_Z: cz = longint'($signed(v));
				CFG_RADIUS: rad = longint'({33'b0, v[30:0]});
				default: ;
			endcase
		endfunction

		function logic [31:0] sat(longint v);
			if (v > S32_MAX) return 32'h7fff_ffff;
			if (v < S32_MIN) return 32'h8000_0000;
			return v[31:0];
		endfunction

		function logic [63:0] isqrt(logic [127:0] x);
			logic [63:0] res, cand;
			res = '0;
			for (int b = 63; b >= 0; b--) begin
				cand = res | (64'd1 << b);
				if ({64'b0, cand} * {64'b0, cand} <= x)
					res = cand;
			end
			return res;
		endfunction

		// Bit-exact intersection of one ray with the current sphere.
		function hit_rec_t trace(ray_t r);
			longint o[3], d[3], oc[3], cc[3], pt[3], t, m, tmin, tmax;
			logic [63:0] ocsq, rsq, a;
			logic signed [159:0] h, hsq, ac, num, q;
			logic [63:0] s;
			hit_rec_t res;
			res = '0;
			cc[0] = cx;
			cc[1] = cy;
			cc[2] = cz;
			ocsq = 0;
			a = 0;
			h = 0;
			for (int i = 0; i < 3; i++) begin
				o[i] = longint'($signed(r.o[i]));
				d[i] = longint'($signed(r.d[i]));
				oc[i] = longint'($signed(sat(o[i] - cc[i])));
				m = oc[i] < 0 ? -oc[i] : oc[i];
				ocsq += m * m;
			end
			if (rad == 0)
				return res;
			rsq = rad * rad;
			if (ocsq < rsq) begin
				t = rad - longint'(isqrt({64'b0, ocsq}));
			end else begin
				for (int i = 0; i < 3; i++) begin
					m = d[i] < 0 ? -d[i] : d[i];
					a += m * m;
					h = h + oc[i] * d[i];
				end
				if (a == 0)
					return res;
				hsq = h * h;
				ac = $signed({96'b0, a}) * $signed({96'b0, ocsq - rsq});
				if (hsq < ac)
					return res;
				s = isqrt(128'(hsq - ac));
				num = (-h - $signed({96'b0, s})) * 160'sd65536;
				q = num / $signed({96'b0, a});
				if (q > S32_MAX || q < S32_MIN)
					return res;
				t = longint'(q);
			end
			tmin = longint'($signed(r.tmin));
			tmax = longint'($signed(r.tmax));
			if (t < tmin || t > tmax)
				return res;
			res.hit = 1'b1;
			res.t = t[31:0];
			for (int i = 0; i < 3; i++) begin
				pt[i] = longint'($signed(sat(o[i] + ((t * d[i]) >>> FRAC))));
				res.p[i] = pt[i][31:0];
				res.n[i] = sat(((pt[i] - cc[i]) * ONE) / rad);
			end
			return res;
		endfunction

		function void note_request(ray_t r);
			hit_q.push_back(trace(r));
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(hit_rec_t got);
			hit_rec_t want;
			if (hit_q.size() == 0) begin
				report("result with no request outstanding");
				return;
			end
			want = hit_q.pop_front();
			if (got.hit !== want.hit)
				report($sformatf("is_hit %0b, expected %0b", got.hit, want.hit));
			if (got.t !== want.t)
				report($sformatf("hit_t %h, expected %h", got.t, want.t));
			for (int i = 0; i < 3; i++) begin
				if (got.p[i] !== want.p[i])
					report($sformatf("point[%0d] %h, expected %h", i, got.p[i], want.p[i]));
				if (got.n[i] !== want.n[i])
					report($sformatf("normal[%0d] %h, expected %h", i, got.n[i], want.n[i]));
			end
		endtask
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic signed [31:0] origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max;
	logic is_hit;
	logic signed [31:0] hit_t, point_x, point_y, point_z, normal_x, normal_y, normal_z;
	logic cfg_valid, cfg_ready;
	cfg_idx_t cfg_index;
	logic [31:0] cfg_data;

	rsi_scoreboard sb;
	int send_idle_pct, recv_idle_pct;
	logic long_hold, hold_taken;
	int hold_left;

	ray_sphere_intersect_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.t_min(t_min), .t_max(t_max),
		.out_valid(out_valid), .out_stall(out_stall),
		.is_hit(is_hit), .hit_t(hit_t),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The receiver stalls at random, or for one long stretch when asked.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_taken <= 1'b0;
		end else if (long_hold && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= 1200;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Outputs are sampled mid-cycle; the result is taken at the next rising edge.
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({is_hit, hit_t, point_z, point_y, point_x,
				normal_z, normal_y, normal_x});
	end

	task send_ray(ray_t r);
		logic take;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		origin_x <= r.o[0];
		origin_y <= r.o[1];
		origin_z <= r.o[2];
		dir_x <= r.d[0];
		dir_y <= r.d[1];
		dir_z <= r.d[2];
		t_min <= r.tmin;
		t_max <= r.tmax;
		do begin
			@(negedge clk);
			take = !in_stall;
			@(posedge clk);
		end while (!take);
		sb.note_request(r);
	endtask

	task write_reg(cfg_idx_t idx, logic [31:0] v);
		logic rdy;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		sb.set_reg(idx, v);
	endtask

	task drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.hit_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function ray_t mk_ray(longint ox, longint oy, longint oz, longint dx, longint dy,
		longint dz, longint lo, longint hi);
		ray_t r;
		r.o[0] = ox[31:0];
		r.o[1] = oy[31:0];
		r.o[2] = oz[31:0];
		r.d[0] = dx[31:0];
		r.d[1] = dy[31:0];
		r.d[2] = dz[31:0];
		r.tmin = lo[31:0];
		r.tmax = hi[31:0];
		return r;
	endfunction

	// Mostly rays aimed near the sphere, with some fully random requests.
	function ray_t gen_ray();
		ray_t r;
		longint sp, off, cc[3];
		int kind, sh;
		kind = $urandom_range(99);
		cc[0] = sb.cx;
		cc[1] = sb.cy;
		cc[2] = sb.cz;
		if (kind < 20) begin
			r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom};
			return r;
		end
		sp = (sb.rad == 0) ? ONE : (kind < 32 ? sb.rad / 2 : sb.rad * 3);
		if (sp > 64'sd1073741824)
			sp = 64'sd1073741824;
		if (sp < 1)
			sp = 1;
		for (int i = 0; i < 3; i++) begin
			off = longint'($urandom_range(0, 32'(2 * sp))) - sp;
			r.o[i] = sb.sat(cc[i] + off);
			sh = $urandom_range(0, 10);
			if (kind < 38)
				r.d[i] = '0;
			else if (kind < 46)
				r.d[i] = $urandom;
			else
				r.d[i] = sb.sat(-(off >>> sh) + longint'($urandom_range(0, 64)) - 32);
		end
		if ($urandom_range(3) == 0) begin
			r.tmin = $urandom;
			r.tmax = $urandom;
		end else begin
			r.tmin = $urandom_range(1) ? 32'h8000_0000 : 32'h0;
			r.tmax = 32'h7fff_ffff;
		end
		return r;
	endfunction

	initial begin
		#5000000;
		$display("status: fail");
		$finish;
	end

	initial begin
		longint cfg_tab[6][4];
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_CENTER_X;
		cfg_data = '0;
		{origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max} = '0;
		long_hold = 1'b0;
		send_idle_pct = 14;
		recv_idle_pct = 80;
		cfg_tab[0] = '{0, 0, 0, ONE};
		cfg_tab[1] = '{688128, -212992, 458752, 163840};
		cfg_tab[2] = '{S32_MAX, S32_MIN, 0, S32_MAX};
		cfg_tab[3] = '{-6553600, 3276800, 66, 1};
		cfg_tab[4] = '{ONE, ONE, ONE, 0};
		cfg_tab[5] = '{longint'($signed($urandom)), longint'($signed($urandom)),
			longint'($signed($urandom)), 4 * ONE};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests against the unit sphere at the origin.
		send_ray(mk_ray(0, 0, -3 * ONE, 0, 0, ONE, S32_MIN, S32_MAX));
		send_ray(mk_ray(ONE / 2, 0, 0, 0, 0, 0, S32_MIN, S32_MAX));
		send_ray(mk_ray(0, 0, 0, ONE, 0, 0, S32_MIN, S32_MAX));
		send_ray(mk_ray(0, 0, -3 * ONE, 0, 0, 0, S32_MIN, S32_MAX));
		send_ray(mk_ray(0, 0, -3 * ONE, 0, 0, -ONE, 0, S32_MAX));
		send_ray(mk_ray(0, 0, -3 * ONE, 0, 0, -ONE, S32_MIN, S32_MAX));
		send_ray(mk_ray(0, 2 * ONE, -3 * ONE, 0, 0, ONE, S32_MIN, S32_MAX));
		send_ray(mk_ray(0, 0, -3 * ONE, 0, 0, ONE, S32_MAX, S32_MIN));
		send_ray(mk_ray(0, 0, -3 * ONE, 0, 0, ONE, 2 * ONE, 2 * ONE));
		send_ray(mk_ray(0, 0, -3 * ONE, 0, 0, ONE, 0, 2 * ONE - 1));
		send_ray(mk_ray(0, 0, -3 * ONE, 0, 0, 1, S32_MIN, S32_MAX));
		send_ray(mk_ray(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX,
			S32_MAX, S32_MAX));
		send_ray(mk_ray(S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN,
			S32_MIN, S32_MIN));
		send_ray(mk_ray(S32_MIN, 0, 0, S32_MAX, 0, 0, S32_MIN, S32_MAX));
		send_ray(mk_ray(0, 0, -ONE, 0, 0, ONE, S32_MIN, S32_MAX));
		send_ray(mk_ray(-5 * ONE, -5 * ONE, -5 * ONE, ONE, ONE, ONE, S32_MIN, S32_MAX));

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			write_reg(CFG_CENTER_X, cfg_tab[ph][0][31:0]);
			write_reg(CFG_CENTER_Y, cfg_tab[ph][1][31:0]);
			write_reg(CFG_CENTER_Z, cfg_tab[ph][2][31:0]);
			write_reg(CFG_RADIUS, cfg_tab[ph][3][31:0]);
			cfg_valid <= 1'b0;
			if (ph == 2) begin
				send_idle_pct = 80;
				recv_idle_pct = 14;
			end else if (ph == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// A long receiver stall while requests keep coming fills the pipeline.
			if (ph == 5)
				long_hold = 1'b1;
			repeat (290) send_ray(gen_ray());
		end
		drain();

		if (sb.hit_q.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.hit_q.size()));
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
